/* rtl/core/assert_macros.svh */
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never be true out of reset.
`define SIPD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("deframer assertion violated");

// Flag an antecedent that is not followed by its consequent in the same cycle.
`define SIPD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion violated");

`endif

/* rtl/core/sipd_pkg.sv */
// Types and constants of the SIP stream deframer.
package sipd_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_D0  = 8'h30;
  localparam logic [7:0] CH_D9  = 8'h39;

  localparam logic [1:0] FORM_SHORT_IDX = 2'd3;
  localparam logic [4:0] FORM_LONG_LEN  = 5'd15;
  localparam logic [4:0] FORM_SHORT_LEN = 5'd2;

  localparam logic [119:0] FORM_UPPER = "Content-Length:";
  localparam logic [119:0] FORM_LOWER = "content-length:";
  localparam logic [119:0] FORM_MIXED = "Content-length:";
  localparam logic [15:0]  FORM_SHORT = "l:";

  typedef struct packed {
    logic done;
    logic over;
  } hdr_ev_t;

  function automatic logic [4:0] form_len(logic [1:0] idx);
    return (idx == FORM_SHORT_IDX) ? FORM_SHORT_LEN : FORM_LONG_LEN;
  endfunction

  function automatic logic [7:0] form_char(logic [1:0] idx, logic [3:0] pos);
    logic [119:0] txt;
    logic [3:0]   p;
    case (idx)
      2'd0: txt = FORM_UPPER;
      2'd1: txt = FORM_LOWER;
      2'd2: txt = FORM_MIXED;
      default: txt = {FORM_SHORT, 104'd0};
    endcase
    p = (pos > 4'd14) ? 4'd14 : pos;
    return txt[119 - 8 * p -: 8];
  endfunction

endpackage

/* rtl/core/sipd_hdr_scan.sv */
// Header scanner: terminator search, length form match and value capture.
`include "assert_macros.svh"

module sipd_hdr_scan #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             data_in,
  output sipd_pkg::hdr_ev_t      ev,
  output logic [LENGTH_BITS-1:0] len
);
  import sipd_pkg::*;

  localparam int VW = LENGTH_BITS + 1;
  localparam int PW = LENGTH_BITS + 5;

  typedef enum logic [1:0] {
    VP_IDLE,
    VP_BLANKS,
    VP_DIGITS
  } vp_t;

  logic [3:0]    cand_r, cand_nxt, cand_m, live;
  logic [4:0]    pos_r, pos_nxt, pos_m;
  vp_t           vp_r, vp_nxt, vp_m;
  logic [1:0]    act_r, act_nxt, act_m;
  logic [3:0]    found_r, found_nxt, found_m;
  logic [1:0]    term_r, term_nxt;
  logic [VW-1:0] val_r [4];
  logic [VW-1:0] val_nxt [4];
  logic [VW-1:0] val_m [4];
  logic [VW-1:0] sel;
  logic [PW-1:0] prod;
  logic [PW-1:0] limit;
  logic          digit, done, line_start;

  assign digit = (data_in >= CH_D0) && (data_in <= CH_D9);
  assign limit = PW'(1) << LENGTH_BITS;
  assign prod  = ({4'd0, val_r[act_r]} << 3) + ({4'd0, val_r[act_r]} << 1)
               + PW'(data_in[3:0]);

  always_comb begin
    cand_m  = cand_r;
    pos_m   = pos_r;
    vp_m    = vp_r;
    act_m   = act_r;
    found_m = found_r;
    val_m   = val_r;
    live    = 4'd0;
    if (cand_r != 4'd0) begin
      for (int i = 0; i < 4; i++) begin
        if (cand_r[i] && (pos_r < form_len(2'(i))) &&
            (form_char(2'(i), pos_r[3:0]) == data_in)) begin
          live[i] = 1'b1;
        end
      end
      pos_m  = (pos_r < 5'd31) ? pos_r + 5'd1 : pos_r;
      cand_m = live;
      for (int i = 0; i < 4; i++) begin
        if (live[i] && (pos_m == form_len(2'(i)))) begin
          cand_m = 4'd0;
          if (!found_r[i]) begin
            found_m[i] = 1'b1;
            val_m[i]   = '0;
            act_m      = 2'(i);
            vp_m       = VP_BLANKS;
          end
        end
      end
    end else begin
      case (vp_r)
        VP_BLANKS: begin
          if (data_in != CH_SP && data_in != CH_TAB) begin
            if (digit) begin
              val_m[act_r] = VW'(data_in[3:0]);
              vp_m         = VP_DIGITS;
            end else begin
              vp_m = VP_IDLE;
            end
          end
        end
        VP_DIGITS: begin
          if (digit) begin
            val_m[act_r] = (prod > limit) ? limit[VW-1:0] : prod[VW-1:0];
          end else begin
            vp_m = VP_IDLE;
          end
        end
        default: vp_m = VP_IDLE;
      endcase
    end
  end

  always_comb begin
    done       = 1'b0;
    line_start = 1'b0;
    term_nxt   = 2'd0;
    if (data_in == CH_CR) begin
      term_nxt = (term_r == 2'd2) ? 2'd3 : 2'd1;
    end else if (data_in == CH_LF) begin
      if (term_r == 2'd3) begin
        done = 1'b1;
      end else if (term_r == 2'd1) begin
        term_nxt   = 2'd2;
        line_start = 1'b1;
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 3; i >= 0; i--) begin
      if (found_m[i]) begin
        sel = val_m[i];
      end
    end
  end

  assign ev.done = done;
  assign ev.over = sel[LENGTH_BITS];
  assign len     = sel[LENGTH_BITS-1:0];

  always_comb begin
    cand_nxt  = cand_m;
    pos_nxt   = pos_m;
    vp_nxt    = vp_m;
    act_nxt   = act_m;
    found_nxt = found_m;
    val_nxt   = val_m;
    if (done) begin
      cand_nxt  = 4'd0;
      pos_nxt   = 5'd0;
      vp_nxt    = VP_IDLE;
      act_nxt   = 2'd0;
      found_nxt = 4'd0;
    end else if (line_start) begin
      cand_nxt = 4'hF;
      pos_nxt  = 5'd0;
      vp_nxt   = VP_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= 4'd0;
      pos_r   <= 5'd0;
      vp_r    <= VP_IDLE;
      act_r   <= 2'd0;
      found_r <= 4'd0;
      term_r  <= 2'd0;
    end else if (step) begin
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
      vp_r    <= vp_nxt;
      act_r   <= act_nxt;
      found_r <= found_nxt;
      term_r  <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      val_r <= val_nxt;
    end
  end

  `SIPD_ASSERT_IMPLIES(a_cand_no_value, clk, rst_n, cand_r != 4'd0, vp_r == VP_IDLE)
  `SIPD_ASSERT_IMPLIES(a_value_found, clk, rst_n, vp_r != VP_IDLE, found_r[act_r])
  `SIPD_ASSERT_NEVER(a_cand_pos, clk, rst_n, (cand_r != 4'd0) && (pos_r >= FORM_LONG_LEN))

endmodule

/* rtl/core/sip_stream_deframer.sv */
// Top level of the SIP stream deframer.
// Usage:
//   in_*  : one stream byte per request, valid/stall; in_stall is driven here.
//   out_* : one result per input byte, the byte echoed with body, header-done,
//           length, message-end and drop flags; out_stall comes from the sink.
//   cfg_* : write of max_body_length, valid/ready; cfg_ready is always high.
//           Write it only while no bytes are in flight.
// An accepted input byte passes through the input register and then the output register to out_*.
// Throughput: 1 byte per cycle while out_stall is low; all per-byte work is one
//   pass of logic between the input register and the output register.
// A stalled output holds its result; the input register still takes a byte
//   and only then stalls the input side.
// Reset (rst_n low, synchronous) empties both registers, returns to the
//   header phase with no length form live and sets max_body_length to 65535.
// A header whose length exceeds max_body_length ends with drop on its last
//   line feed and no body; the next byte starts a new header search.
`include "assert_macros.svh"

module sip_stream_deframer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_in_body,
  output logic        out_header_done,
  output logic [15:0] out_body_length,
  output logic        out_message_end,
  output logic        out_drop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_body_length
);
  import sipd_pkg::*;

  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic                   adv, hdr_step;
  logic [15:0]            maxlen_r;
  logic                   phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt, rem_dec;
  hdr_ev_t                ev;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic [CW-1:0]          len_w, max_w;
  logic                   body_nxt, done_nxt, mend_nxt, drop_nxt;
  logic [15:0]            blen_nxt;

  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_body_r, out_done_r, out_mend_r, out_drop_r;
  logic [15:0]            out_blen_r;

  assign adv       = in_vld_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign hdr_step  = adv && !phase_r;
  assign cfg_ready = 1'b1;

  sipd_hdr_scan #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (hdr_step),
    .data_in(in_byte_r),
    .ev     (ev),
    .len    (hdr_len)
  );

  assign len_w   = CW'(hdr_len);
  assign max_w   = CW'(maxlen_r);
  assign rem_dec = (rem_r != '0) ? rem_r - LENGTH_BITS'(1) : rem_r;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    body_nxt  = 1'b0;
    done_nxt  = 1'b0;
    mend_nxt  = 1'b0;
    drop_nxt  = 1'b0;
    blen_nxt  = 16'd0;
    if (phase_r) begin
      body_nxt = 1'b1;
      rem_nxt  = rem_dec;
      if (rem_dec == '0) begin
        mend_nxt  = 1'b1;
        phase_nxt = 1'b0;
      end
    end else if (ev.done) begin
      done_nxt = 1'b1;
      if (ev.over || (len_w > max_w)) begin
        drop_nxt = 1'b1;
      end else begin
        blen_nxt = len_w[15:0];
        if (hdr_len == '0) begin
          mend_nxt = 1'b1;
        end else begin
          rem_nxt   = hdr_len;
          phase_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      rem_r       <= '0;
      maxlen_r    <= 16'hFFFF;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        rem_r       <= rem_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        maxlen_r <= cfg_max_body_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
    end
    if (adv) begin
      out_byte_r <= in_byte_r;
      out_body_r <= body_nxt;
      out_done_r <= done_nxt;
      out_mend_r <= mend_nxt;
      out_drop_r <= drop_nxt;
      out_blen_r <= blen_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_in_body     = out_body_r;
  assign out_header_done = out_done_r;
  assign out_body_length = out_blen_r;
  assign out_message_end = out_mend_r;
  assign out_drop        = out_drop_r;

  `SIPD_ASSERT_IMPLIES(a_body_has_rem, clk, rst_n, phase_r, rem_r != '0)
  `SIPD_ASSERT_NEVER(a_drop_and_end, clk, rst_n, out_valid_r && out_drop_r && out_mend_r)
  `SIPD_ASSERT_IMPLIES(a_drop_at_done, clk, rst_n, out_valid_r && out_drop_r, out_done_r)
  `SIPD_ASSERT_NEVER(a_body_not_done, clk, rst_n, out_valid_r && out_body_r && out_done_r)

endmodule
